// ===== hw/rtl/rpn_pkg.sv =====
// shared types, constants and symbol decoding for the rpn stack evaluator
`default_nettype none

package rpn_pkg;

   localparam int STACK_DEPTH = 128;
   localparam int DEPTH_W     = $clog2(STACK_DEPTH + 1);
   localparam int ADDR_W      = $clog2(STACK_DEPTH);
   localparam int DATA_W      = 32;
   localparam int STATUS_W    = 3;
   localparam int SYMBOL_W    = 8;
   localparam int DIGIT_W     = 4;
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
   localparam int DIV_CNT_W   = $clog2(DATA_W);

   localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
   localparam logic [STATUS_W-1:0] ST_OVERFLOW  = 3'd1;
   localparam logic [STATUS_W-1:0] ST_UNDERFLOW = 3'd2;
   localparam logic [STATUS_W-1:0] ST_INVALID   = 3'd3;
   localparam logic [STATUS_W-1:0] ST_DIVZERO   = 3'd4;

   localparam logic [SYMBOL_W-1:0] CH_ZERO  = 8'h30;
   localparam logic [SYMBOL_W-1:0] CH_NINE  = 8'h39;
   localparam logic [SYMBOL_W-1:0] CH_PLUS  = 8'h2b;
   localparam logic [SYMBOL_W-1:0] CH_MINUS = 8'h2d;
   localparam logic [SYMBOL_W-1:0] CH_STAR  = 8'h2a;
   localparam logic [SYMBOL_W-1:0] CH_SLASH = 8'h2f;
   localparam logic [SYMBOL_W-1:0] CH_EQUAL = 8'h3d;
   localparam logic [SYMBOL_W-1:0] CH_SPACE = 8'h20;
   localparam logic [SYMBOL_W-1:0] CH_TAB   = 8'h09;
   localparam logic [SYMBOL_W-1:0] CH_CR    = 8'h0d;

   typedef enum logic [2:0] {
      OP_PUSH,
      OP_EQUAL,
      OP_ADD,
      OP_SUB,
      OP_MUL,
      OP_DIV,
      OP_BAD
   } op_type;

   typedef struct packed {
      op_type              op;
      logic [DIGIT_W-1:0]  digit;
   } cmd_type;

   typedef enum logic [1:0] {
      BK_IDLE,
      BK_EXEC,
      BK_DIV,
      BK_EMIT
   } back_state_type;

   // tab, lf, vt, ff, cr and space
   function automatic logic is_blank(input logic [SYMBOL_W-1:0] sym);
      return (sym == CH_SPACE) || ((sym >= CH_TAB) && (sym <= CH_CR));
   endfunction

   function automatic cmd_type classify(input logic [SYMBOL_W-1:0] sym);
      cmd_type cmd;
      logic [SYMBOL_W-1:0] diff;
      diff      = sym - CH_ZERO;
      cmd.digit = diff[DIGIT_W-1:0];
      if ((sym >= CH_ZERO) && (sym <= CH_NINE)) begin
         cmd.op = OP_PUSH;
      end else if (sym == CH_EQUAL) begin
         cmd.op = OP_EQUAL;
      end else if (sym == CH_PLUS) begin
         cmd.op = OP_ADD;
      end else if (sym == CH_MINUS) begin
         cmd.op = OP_SUB;
      end else if (sym == CH_STAR) begin
         cmd.op = OP_MUL;
      end else if (sym == CH_SLASH) begin
         cmd.op = OP_DIV;
      end else begin
         cmd.op = OP_BAD;
      end
      return cmd;
   endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/rpn_ifs.sv =====
// valid/ready channel interfaces for symbol items and result items
`default_nettype none

interface rpn_req_if
   import rpn_pkg::*;
   ;
   logic                valid;
   logic                ready;
   logic [SYMBOL_W-1:0] symbol;

   modport source (output valid, output symbol, input ready);
   modport sink   (input valid, input symbol, output ready);
endinterface

interface rpn_rsp_if
   import rpn_pkg::*;
   ;
   logic                     valid;
   logic                     ready;
   logic signed [DATA_W-1:0] value;
   logic [STATUS_W-1:0]      status;

   modport source (output valid, output value, output status, input ready);
   modport sink   (input valid, input value, input status, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/rpn_front.sv =====
// front end: takes symbol items, drops blanks and decodes the rest into commands
`default_nettype none

module rpn_front
   import rpn_pkg::*;
(
   input  wire logic   clock,
   input  wire logic   reset,
   rpn_req_if.sink     req,
   output cmd_type     cmd_out,
   output logic        cmd_valid,
   input  wire logic   cmd_ready
);

   logic    valid_ff, valid_in;
   cmd_type cmd_ff, cmd_in;
   logic    accept;

   assign req.ready = !valid_ff || cmd_ready;
   assign accept    = req.valid && req.ready;

   always_comb begin
      valid_in = valid_ff && !cmd_ready;
      cmd_in   = cmd_ff;
      if (accept && !is_blank(req.symbol)) begin
         valid_in = 1'b1;
         cmd_in   = classify(req.symbol);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      cmd_ff <= cmd_in;
   end

   assign cmd_out   = cmd_ff;
   assign cmd_valid = valid_ff;

endmodule

`default_nettype wire

// ===== hw/rtl/rpn_queue.sv =====
// short command queue between front end and execution unit
`default_nettype none

module rpn_queue
   import rpn_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire cmd_type push_cmd,
   input  wire logic    push_valid,
   output logic         push_ready,
   output cmd_type      pop_cmd,
   output logic         pop_valid,
   input  wire logic    pop_ready
);

   cmd_type             entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]   count_ff, count_in;
   logic                do_push, do_pop;

   assign push_ready = (count_ff != QCNT_W'(QUEUE_DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_cmd    = entry_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   function automatic logic [QPTR_W-1:0] next_ptr(input logic [QPTR_W-1:0] p);
      if (p == QPTR_W'(QUEUE_DEPTH - 1)) begin
         return '0;
      end
      return p + 1'b1;
   endfunction

   always_comb begin
      wr_ptr_in = do_push ? next_ptr(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = do_pop ? next_ptr(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

`default_nettype wire

// ===== hw/rtl/rpn_div.sv =====
// iterative signed divider, one quotient bit per cycle, truncates toward zero
`default_nettype none

module rpn_div
   import rpn_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   input  wire logic [DATA_W-1:0] dividend,
   input  wire logic [DATA_W-1:0] divisor,
   output logic                   busy,
   output logic                   done,
   output logic [DATA_W-1:0]      quotient
);

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic                 neg_ff, neg_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic [DATA_W:0]      rem_ff, rem_in;
   logic [DATA_W-1:0]    quo_ff, quo_in;
   logic [DATA_W-1:0]    dvs_ff, dvs_in;
   logic [DATA_W:0]      rem_sh, diff;

   assign rem_sh = {rem_ff[DATA_W-1:0], quo_ff[DATA_W-1]};
   assign diff   = rem_sh - {1'b0, dvs_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      neg_in  = neg_ff;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dvs_in  = dvs_ff;
      if (start) begin
         busy_in = 1'b1;
         neg_in  = dividend[DATA_W-1] ^ divisor[DATA_W-1];
         cnt_in  = '0;
         rem_in  = '0;
         quo_in  = dividend[DATA_W-1] ? (~dividend + 1'b1) : dividend;
         dvs_in  = divisor[DATA_W-1] ? (~divisor + 1'b1) : divisor;
      end else if (busy_ff) begin
         if (!diff[DATA_W]) begin
            rem_in = diff;
            quo_in = {quo_ff[DATA_W-2:0], 1'b1};
         end else begin
            rem_in = rem_sh;
            quo_in = {quo_ff[DATA_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == DIV_CNT_W'(DATA_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      neg_ff <= neg_in;
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
   end

   assign busy     = busy_ff;
   assign done     = done_ff;
   assign quotient = neg_ff ? (~quo_ff + 1'b1) : quo_ff;

endmodule

`default_nettype wire

// ===== hw/rtl/rpn_back.sv =====
// execution unit: operand stack, arithmetic and result register
`default_nettype none

module rpn_back
   import rpn_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire cmd_type cmd_in_q,
   input  wire logic    cmd_valid,
   output logic         cmd_pop,
   rpn_rsp_if.source    rsp
);

   back_state_type      state_ff, state_in;
   cmd_type             cmd_ff, cmd_in;
   logic [DEPTH_W-1:0]  depth_ff, depth_in;
   logic [DATA_W-1:0]   top_ff, top_in;
   logic [DATA_W-1:0]   below_ff;
   logic [DATA_W-1:0]   stack_mem [STACK_DEPTH];
   logic [DEPTH_W-1:0]  wr_depth, rd_depth;
   logic [ADDR_W-1:0]   wr_addr, rd_addr;
   logic                mem_we;

   logic [DATA_W-1:0]   res_value_ff, res_value_in;
   logic [STATUS_W-1:0] res_status_ff, res_status_in;
   logic                out_valid_ff, out_valid_in;
   logic [DATA_W-1:0]   out_value_ff, out_value_in;
   logic [STATUS_W-1:0] out_status_ff, out_status_in;
   logic                slot_free;

   logic                overflow, too_few, div_zero, stack_empty;
   logic [DATA_W-1:0]   sum, dif, prod;
   logic                div_start, div_busy, div_done;
   logic [DATA_W-1:0]   div_quot;

   assign wr_depth = depth_ff - 1'b1;
   assign rd_depth = depth_ff - DEPTH_W'(2);
   assign wr_addr  = wr_depth[ADDR_W-1:0];
   assign rd_addr  = rd_depth[ADDR_W-1:0];

   assign overflow    = (depth_ff >= DEPTH_W'(STACK_DEPTH));
   assign too_few     = (depth_ff < DEPTH_W'(2));
   assign stack_empty = (depth_ff == '0);
   assign div_zero    = (top_ff == '0);
   assign slot_free   = !out_valid_ff || rsp.ready;

   assign sum  = below_ff + top_ff;
   assign dif  = below_ff - top_ff;
   assign prod = below_ff * top_ff;

   rpn_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (below_ff),
      .divisor  (top_ff),
      .busy     (div_busy),
      .done     (div_done),
      .quotient (div_quot)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         BK_IDLE: begin
            if (cmd_valid) begin
               state_in = BK_EXEC;
            end
         end
         BK_EXEC: begin
            unique case (cmd_ff.op)
               OP_PUSH:  state_in = overflow ? BK_EMIT : BK_IDLE;
               OP_EQUAL: state_in = BK_EMIT;
               OP_BAD:   state_in = BK_EMIT;
               OP_DIV:   state_in = (too_few || div_zero) ? BK_EMIT : BK_DIV;
               default:  state_in = too_few ? BK_EMIT : BK_IDLE;
            endcase
         end
         BK_DIV: begin
            if (div_done) begin
               state_in = BK_IDLE;
            end
         end
         BK_EMIT: begin
            if (slot_free) begin
               state_in = BK_IDLE;
            end
         end
         default: state_in = BK_IDLE;
      endcase
   end

   // datapath and outputs
   always_comb begin
      cmd_pop       = 1'b0;
      cmd_in        = cmd_ff;
      depth_in      = depth_ff;
      top_in        = top_ff;
      mem_we        = 1'b0;
      div_start     = 1'b0;
      res_value_in  = res_value_ff;
      res_status_in = res_status_ff;
      out_valid_in  = out_valid_ff && !rsp.ready;
      out_value_in  = out_value_ff;
      out_status_in = out_status_ff;
      unique case (state_ff)
         BK_IDLE: begin
            if (cmd_valid) begin
               cmd_pop = 1'b1;
               cmd_in  = cmd_in_q;
            end
         end
         BK_EXEC: begin
            res_value_in = '0;
            unique case (cmd_ff.op)
               OP_PUSH: begin
                  if (overflow) begin
                     res_status_in = ST_OVERFLOW;
                     depth_in      = '0;
                  end else begin
                     mem_we   = !stack_empty;
                     top_in   = DATA_W'(cmd_ff.digit);
                     depth_in = depth_ff + 1'b1;
                  end
               end
               OP_EQUAL: begin
                  depth_in = '0;
                  if (stack_empty) begin
                     res_status_in = ST_UNDERFLOW;
                  end else begin
                     res_status_in = ST_OK;
                     res_value_in  = top_ff;
                  end
               end
               OP_BAD: begin
                  res_status_in = ST_INVALID;
                  depth_in      = '0;
               end
               OP_DIV: begin
                  if (too_few) begin
                     res_status_in = ST_UNDERFLOW;
                     depth_in      = '0;
                  end else if (div_zero) begin
                     res_status_in = ST_DIVZERO;
                     depth_in      = '0;
                  end else begin
                     div_start = 1'b1;
                  end
               end
               default: begin
                  if (too_few) begin
                     res_status_in = ST_UNDERFLOW;
                     depth_in      = '0;
                  end else begin
                     depth_in = depth_ff - 1'b1;
                     if (cmd_ff.op == OP_ADD) begin
                        top_in = sum;
                     end else if (cmd_ff.op == OP_SUB) begin
                        top_in = dif;
                     end else begin
                        top_in = prod;
                     end
                  end
               end
            endcase
         end
         BK_DIV: begin
            if (div_done) begin
               top_in   = div_quot;
               depth_in = depth_ff - 1'b1;
            end
         end
         BK_EMIT: begin
            if (slot_free) begin
               out_valid_in  = 1'b1;
               out_value_in  = res_value_ff;
               out_status_in = res_status_ff;
            end
         end
         default: begin
            cmd_in = cmd_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_IDLE;
         depth_ff     <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         depth_ff     <= depth_in;
         out_valid_ff <= out_valid_in;
      end
      cmd_ff        <= cmd_in;
      top_ff        <= top_in;
      res_value_ff  <= res_value_in;
      res_status_ff <= res_status_in;
      out_value_ff  <= out_value_in;
      out_status_ff <= out_status_in;
   end

   // stack below the top entry
   always_ff @(posedge clock) begin
      if (mem_we) begin
         stack_mem[wr_addr] <= top_ff;
      end
      below_ff <= stack_mem[rd_addr];
   end

   assign rsp.valid  = out_valid_ff;
   assign rsp.value  = $signed(out_value_ff);
   assign rsp.status = out_status_ff;

`ifndef SYNTHESIS
   a_depth_bound: assert property (@(posedge clock) disable iff (reset)
      depth_ff <= DEPTH_W'(STACK_DEPTH))
      else $error("stack depth beyond capacity");

   a_emit_empties: assert property (@(posedge clock) disable iff (reset)
      (state_ff == BK_EMIT) |-> (depth_ff == '0))
      else $error("stack not cleared before result");

   a_err_value_zero: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && (out_status_ff != ST_OK)) |-> (out_value_ff == '0))
      else $error("error result with nonzero value");

   a_push_grows: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == BK_EXEC) && (cmd_ff.op == OP_PUSH) && !overflow)
      |=> (depth_ff == $past(depth_ff) + 1'b1))
      else $error("push did not grow the stack");

   a_div_wait: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == BK_DIV) && !div_done) |-> div_busy)
      else $error("waiting on an idle divider");
`endif

endmodule

`default_nettype wire

// ===== hw/rtl/rpn_stack_evaluator.sv =====
// rpn stack evaluator: postfix expression evaluation on 32-bit signed integers
//
// req carries one ascii symbol per item: digits push, + - * / combine the two
// top entries, = returns the top entry and empties the stack. blanks are
// dropped in the front end and give no result. errors (overflow, underflow,
// invalid symbol, divide by zero) return one rsp item with value 0 and the
// error status, and empty the stack.
// the front end takes one item per cycle, unless it backs up, into a two-entry
// command queue. the execution unit passes through idle and exec states for a
// push, add, subtract or multiply, through an emit state as well for = or an
// error, and waits in a div state on the one-bit-per-cycle divider for a divide.
// rsp is a registered output: while the receiver stalls, one result is held
// and the execution unit waits at its next result; req backs up once the
// queue and front register are full.
// reset is synchronous: it empties the stack and drops queued items and any
// pending result. the stack memory needs no clearing pass.
`default_nettype none

module rpn_stack_evaluator
   import rpn_pkg::*;
(
   input  wire logic clock,
   input  wire logic reset,
   rpn_req_if.sink   req,
   rpn_rsp_if.source rsp
);

   cmd_type front_cmd, queue_cmd;
   logic    front_valid, front_ready;
   logic    queue_valid, queue_pop;

   rpn_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req       (req),
      .cmd_out   (front_cmd),
      .cmd_valid (front_valid),
      .cmd_ready (front_ready)
   );

   rpn_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_cmd   (front_cmd),
      .push_valid (front_valid),
      .push_ready (front_ready),
      .pop_cmd    (queue_cmd),
      .pop_valid  (queue_valid),
      .pop_ready  (queue_pop)
   );

   rpn_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_in_q  (queue_cmd),
      .cmd_valid (queue_valid),
      .cmd_pop   (queue_pop),
      .rsp       (rsp)
   );

endmodule

`default_nettype wire

// ===== tb/rpn_stack_evaluator_tb.sv =====
// testbench for rpn_stack_evaluator: directed table, then random streams checked by a predictor
`default_nettype none

module rpn_stack_evaluator_tb
   import rpn_pkg::*;
;

   localparam int RANDOM_ITEMS    = 1250;
   localparam int QUIET_TAIL      = 120;
   localparam int MAX_GAP         = 17;
   localparam int WATCHDOG_LIMIT  = 4000;
   localparam int PRESSURE_START  = 1500;
   localparam int PRESSURE_CYCLES = 400;
   localparam int DRAIN_CYCLES    = 48;

   localparam logic [SYMBOL_W-1:0] CH_LF = 8'h0a;
   localparam logic [SYMBOL_W-1:0] CH_VT = 8'h0b;
   localparam logic [SYMBOL_W-1:0] CH_FF = 8'h0c;

   typedef struct packed {
      logic [DATA_W-1:0]   value;
      logic [STATUS_W-1:0] status;
   } outcome_type;

   typedef struct packed {
      logic [SYMBOL_W-1:0] symbol;
      logic                fixed;
      logic [DATA_W-1:0]   value;
      logic [STATUS_W-1:0] status;
   } stim_row_type;

   localparam stim_row_type DIRECTED_PLAN [27] = '{
      '{CH_EQUAL,          1'b1, 32'd0,   ST_UNDERFLOW},
      '{CH_PLUS,           1'b1, 32'd0,   ST_UNDERFLOW},
      '{CH_NINE,           1'b0, 32'd0,   ST_OK},
      '{CH_NINE,           1'b0, 32'd0,   ST_OK},
      '{CH_STAR,           1'b0, 32'd0,   ST_OK},
      '{CH_EQUAL,          1'b1, 32'd81,  ST_OK},
      '{CH_SPACE,          1'b0, 32'd0,   ST_OK},
      '{8'hff,             1'b1, 32'd0,   ST_INVALID},
      '{8'h00,             1'b1, 32'd0,   ST_INVALID},
      '{CH_ZERO + 8'd5,    1'b0, 32'd0,   ST_OK},
      '{CH_ZERO,           1'b0, 32'd0,   ST_OK},
      '{CH_SLASH,          1'b1, 32'd0,   ST_DIVZERO},
      '{CH_ZERO + 8'd7,    1'b0, 32'd0,   ST_OK},
      '{CH_MINUS,          1'b1, 32'd0,   ST_UNDERFLOW},
      '{CH_ZERO + 8'd3,    1'b0, 32'd0,   ST_OK},
      '{CH_TAB,            1'b0, 32'd0,   ST_OK},
      '{CH_ZERO + 8'd8,    1'b0, 32'd0,   ST_OK},
      '{CH_MINUS,          1'b0, 32'd0,   ST_OK},
      '{CH_ZERO + 8'd2,    1'b0, 32'd0,   ST_OK},
      '{CH_SLASH,          1'b0, 32'd0,   ST_OK},
      '{CH_CR,             1'b0, 32'd0,   ST_OK},
      '{CH_EQUAL,          1'b1, -32'sd2, ST_OK},
      '{8'h61,             1'b1, 32'd0,   ST_INVALID},
      '{CH_LF,             1'b0, 32'd0,   ST_OK},
      '{CH_VT,             1'b0, 32'd0,   ST_OK},
      '{CH_FF,             1'b0, 32'd0,   ST_OK},
      '{CH_EQUAL,          1'b1, 32'd0,   ST_UNDERFLOW}
   };

   localparam logic [SYMBOL_W-1:0] BLANKS [6] = '{CH_SPACE, CH_TAB, CH_LF, CH_VT, CH_FF, CH_CR};
   localparam logic [SYMBOL_W-1:0] OPERATORS [4] = '{CH_PLUS, CH_MINUS, CH_STAR, CH_SLASH};

   logic clock;
   logic reset;

   rpn_req_if req_ch ();
   rpn_rsp_if rsp_ch ();

   rpn_stack_evaluator u_top (
      .clock (clock),
      .reset (reset),
      .req   (req_ch),
      .rsp   (rsp_ch)
   );

   logic [DATA_W-1:0] calc_stack [STACK_DEPTH];
   int                calc_depth;
   outcome_type       pending_results [$];
   outcome_type       oldest_result;
   int                symbols_sent;
   int                results_checked;
   int                mismatches;
   int                status_seen [8];
   int                cycle_count;
   int                stalled_cycles;
   logic              quiet;

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   function automatic void evaluate_symbol(input logic [SYMBOL_W-1:0] sym,
                                           output bit produced, output outcome_type out);
      op_type            op;
      logic [DATA_W-1:0] lhs;
      logic [DATA_W-1:0] rhs;
      logic [DATA_W-1:0] res;
      longint            quotient;
      produced = 1'b1;
      out      = '{value: '0, status: ST_OK};
      if ((sym == CH_SPACE) || ((sym >= CH_TAB) && (sym <= CH_CR))) begin
         produced = 1'b0;
         return;
      end
      if ((sym >= CH_ZERO) && (sym <= CH_NINE)) begin
         op = OP_PUSH;
      end else if (sym == CH_EQUAL) begin
         op = OP_EQUAL;
      end else if (sym == CH_PLUS) begin
         op = OP_ADD;
      end else if (sym == CH_MINUS) begin
         op = OP_SUB;
      end else if (sym == CH_STAR) begin
         op = OP_MUL;
      end else if (sym == CH_SLASH) begin
         op = OP_DIV;
      end else begin
         op = OP_BAD;
      end
      case (op)
         OP_PUSH: begin
            if (calc_depth >= STACK_DEPTH) begin
               calc_depth = 0;
               out.status = ST_OVERFLOW;
            end else begin
               calc_stack[calc_depth] = {24'd0, sym - CH_ZERO};
               calc_depth++;
               produced = 1'b0;
            end
         end
         OP_EQUAL: begin
            if (calc_depth == 0) begin
               out.status = ST_UNDERFLOW;
            end else begin
               out.value = calc_stack[calc_depth-1];
            end
            calc_depth = 0;
         end
         OP_BAD: begin
            calc_depth = 0;
            out.status = ST_INVALID;
         end
         default: begin
            if (calc_depth < 2) begin
               calc_depth = 0;
               out.status = ST_UNDERFLOW;
               return;
            end
            rhs = calc_stack[calc_depth-1];
            lhs = calc_stack[calc_depth-2];
            case (op)
               OP_ADD: res = lhs + rhs;
               OP_SUB: res = lhs - rhs;
               OP_MUL: res = lhs * rhs;
               default: begin
                  if (rhs == '0) begin
                     calc_depth = 0;
                     out.status = ST_DIVZERO;
                     return;
                  end
                  // 64-bit quotient so the most negative value over -1 wraps
                  quotient = longint'($signed(lhs)) / longint'($signed(rhs));
                  res      = quotient[DATA_W-1:0];
               end
            endcase
            calc_depth--;
            calc_stack[calc_depth-1] = res;
            produced = 1'b0;
         end
      endcase
   endfunction

   task automatic offer_symbol(input logic [SYMBOL_W-1:0] sym);
      if (!quiet && (((symbols_sent / 80) % 3) != 2) && ($urandom_range(0, 4) == 0)) begin
         req_ch.valid <= 1'b0;
         repeat ($urandom_range(1, MAX_GAP)) @(posedge clock);
      end
      req_ch.valid  <= 1'b1;
      req_ch.symbol <= sym;
      do @(posedge clock); while (!req_ch.ready);
      symbols_sent++;
   endtask

   task automatic send_symbol(input logic [SYMBOL_W-1:0] sym);
      bit          produced;
      outcome_type out;
      offer_symbol(sym);
      evaluate_symbol(sym, produced, out);
      if (produced) begin
         pending_results.push_back(out);
      end
   endtask

   function automatic logic [SYMBOL_W-1:0] random_digit();
      return CH_ZERO + 8'($urandom_range(0, 9));
   endfunction

   // well-formed postfix expression with random digits, operators and blanks
   task automatic send_expression();
      int operands;
      int pushed;
      int depth;
      operands = $urandom_range(1, ($urandom_range(0, 3) == 0) ? 12 : 5);
      pushed   = 0;
      depth    = 0;
      while ((pushed < operands) || (depth > 1)) begin
         if ((pushed < operands) && ((depth < 2) || ($urandom_range(0, 1) == 1))) begin
            send_symbol(random_digit());
            pushed++;
            depth++;
         end else begin
            send_symbol(OPERATORS[$urandom_range(0, 3)]);
            depth--;
         end
         if ($urandom_range(0, 15) == 0) begin
            send_symbol(BLANKS[$urandom_range(0, 5)]);
         end
      end
      send_symbol(CH_EQUAL);
   endtask

   // builds the most negative value as 8^10 * 2, then divides, steps over or returns it
   task automatic send_most_negative();
      repeat (10) send_symbol(CH_ZERO + 8'd8);
      repeat (9) send_symbol(CH_STAR);
      send_symbol(CH_ZERO + 8'd2);
      send_symbol(CH_STAR);
      case ($urandom_range(0, 2))
         0: begin
            send_symbol(CH_ZERO);
            send_symbol(CH_ZERO + 8'd1);
            send_symbol(CH_MINUS);
            send_symbol(CH_SLASH);
         end
         1: begin
            send_symbol(CH_ZERO + 8'd1);
            send_symbol(CH_MINUS);
         end
         default: ;
      endcase
      send_symbol(CH_EQUAL);
   endtask

   task automatic send_broken();
      repeat ($urandom_range(1, 6)) begin
         case ($urandom_range(0, 2))
            0: send_symbol(random_digit());
            1: send_symbol(OPERATORS[$urandom_range(0, 3)]);
            default: send_symbol(CH_EQUAL);
         endcase
      end
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (pending_results.size() == 0) begin
            $error("unexpected result: value %0d status %0d", rsp_ch.value, rsp_ch.status);
            mismatches++;
         end else begin
            oldest_result = pending_results.pop_front();
            results_checked++;
            status_seen[oldest_result.status]++;
            if (rsp_ch.value !== oldest_result.value) begin
               $error("value: expected %0d, got %0d", $signed(oldest_result.value),
                      rsp_ch.value);
               mismatches++;
            end
            if (rsp_ch.status !== oldest_result.status) begin
               $error("status: expected %0d, got %0d", oldest_result.status, rsp_ch.status);
               mismatches++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
         stalled_cycles <= 0;
      end else if (stalled_cycles >= WATCHDOG_LIMIT) begin
         $display("rpn_stack_evaluator_tb failed");
         $finish;
      end else begin
         stalled_cycles <= stalled_cycles + 1;
      end
   end

   initial begin
      bit pressure_done;
      pressure_done = 1'b0;
      rsp_ch.ready  = 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (!pressure_done && !quiet && (cycle_count >= PRESSURE_START)) begin
            rsp_ch.ready <= 1'b0;
            repeat (PRESSURE_CYCLES) @(posedge clock);
            pressure_done = 1'b1;
         end else if (!quiet && (((cycle_count / 300) % 3) != 0) &&
                      ($urandom_range(0, 3) == 0)) begin
            rsp_ch.ready <= 1'b0;
            repeat ($urandom_range(1, MAX_GAP)) @(posedge clock);
         end else begin
            rsp_ch.ready <= 1'b1;
            @(posedge clock);
         end
      end
   end

   initial begin
      bit          produced;
      outcome_type out;
      int          pick;
      int          total;
      reset           = 1'b1;
      req_ch.valid    = 1'b0;
      req_ch.symbol   = '0;
      quiet           = 1'b0;
      calc_depth      = 0;
      symbols_sent    = 0;
      results_checked = 0;
      mismatches      = 0;
      cycle_count     = 0;
      stalled_cycles  = 0;
      foreach (status_seen[i]) status_seen[i] = 0;
      total = $size(DIRECTED_PLAN) + RANDOM_ITEMS;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      foreach (DIRECTED_PLAN[i]) begin
         offer_symbol(DIRECTED_PLAN[i].symbol);
         evaluate_symbol(DIRECTED_PLAN[i].symbol, produced, out);
         if (DIRECTED_PLAN[i].fixed) begin
            pending_results.push_back('{value: DIRECTED_PLAN[i].value,
                                        status: DIRECTED_PLAN[i].status});
         end else if (produced) begin
            pending_results.push_back(out);
         end
      end

      while (symbols_sent < total) begin
         if (symbols_sent >= total - QUIET_TAIL) begin
            quiet <= 1'b1;
         end
         pick = $urandom_range(0, 99);
         if (pick < 65) begin
            send_expression();
         end else if (pick < 70) begin
            send_most_negative();
         end else if (pick < 72) begin
            // fill the stack to around its limit, sometimes past it
            repeat ($urandom_range(STACK_DEPTH - 1, STACK_DEPTH + 2)) send_symbol(random_digit());
            send_symbol(CH_EQUAL);
         end else if (pick < 85) begin
            send_broken();
         end else begin
            repeat ($urandom_range(1, 4)) send_symbol(8'($urandom_range(0, 255)));
         end
      end
      req_ch.valid <= 1'b0;

      while (pending_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("%0d symbols accepted, %0d results checked, %0d mismatches", symbols_sent,
               results_checked, mismatches);
      $display("results by status: ok %0d, overflow %0d, underflow %0d, invalid %0d, div0 %0d",
               status_seen[ST_OK], status_seen[ST_OVERFLOW], status_seen[ST_UNDERFLOW],
               status_seen[ST_INVALID], status_seen[ST_DIVZERO]);
      if (mismatches == 0) begin
         $display("rpn_stack_evaluator_tb passed");
      end else begin
         $display("rpn_stack_evaluator_tb failed");
      end
      $finish;
   end

endmodule

`default_nettype wire

// ===== rpn_stack_evaluator.f =====
hw/rtl/rpn_pkg.sv
hw/rtl/rpn_ifs.sv
hw/rtl/rpn_front.sv
hw/rtl/rpn_queue.sv
hw/rtl/rpn_div.sv
hw/rtl/rpn_back.sv
hw/rtl/rpn_stack_evaluator.sv
tb/rpn_stack_evaluator_tb.sv
